// ===== hw/rtl/fbc_pkg.sv =====
package fbc_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 1000;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned LEFT_W          = 10;

   localparam logic [7:0]  SYNC_A       = 8'h59;
   localparam logic [7:0]  SYNC_B       = 8'h5A;
   localparam logic [7:0]  VERSION_BYTE = 8'h31;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES     = 32'hFFFFFFFF;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // one queued unit of work for the back end
   typedef struct packed {
      logic        is_start;
      logic [7:0]  value;     // frame type on start, data byte otherwise
      logic [15:0] length;
      logic        close;     // append the CRC after this item's bytes
   } cmd_type;

endpackage

// ===== hw/rtl/fbc_front.sv =====
module fbc_front
   import fbc_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_frame_type,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        push,
   output cmd_type     push_cmd
);

   logic [LEFT_W-1:0] left_ff, left_in;
   logic              in_frame_ff, in_frame_in;
   logic [LEFT_W-1:0] eff_len;
   logic              accept;

   assign accept  = req_valid && req_ready;
   assign eff_len = (req_payload_length < 16'(MAX_PAYLOAD))
                    ? req_payload_length[LEFT_W-1:0] : LEFT_W'(MAX_PAYLOAD);

   always_comb begin
      left_in     = left_ff;
      in_frame_in = in_frame_ff;
      push        = 1'b0;
      push_cmd.is_start = (req_kind == KIND_START);
      push_cmd.length   = req_payload_length;
      push_cmd.value    = (req_kind == KIND_START) ? req_frame_type : req_data_byte;
      push_cmd.close    = 1'b0;
      if (accept) begin
         if (req_kind == KIND_START) begin
            push           = 1'b1;
            push_cmd.close = (eff_len == '0);
            left_in        = eff_len;
            in_frame_in    = (eff_len != '0);
         end else if (in_frame_ff && left_ff != '0) begin
            push           = 1'b1;
            push_cmd.close = (left_ff == LEFT_W'(1));
            left_in        = left_ff - LEFT_W'(1);
            in_frame_in    = (left_ff != LEFT_W'(1));
         end
         // drop payload beats outside a frame
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         left_ff     <= left_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ===== hw/rtl/fbc_queue.sv =====
module fbc_queue
   import fbc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    not_full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_full   = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/fbc_back.sv =====
module fbc_back
   import fbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_frame
);

   localparam logic [3:0] PH_SYNC_A  = 4'd0;
   localparam logic [3:0] PH_SYNC_B  = 4'd1;
   localparam logic [3:0] PH_VERSION = 4'd2;
   localparam logic [3:0] PH_TYPE    = 4'd3;
   localparam logic [3:0] PH_LEN_HI  = 4'd4;
   localparam logic [3:0] PH_LEN_LO  = 4'd5;   // also the data byte slot
   localparam logic [3:0] PH_CRC_3   = 4'd6;
   localparam logic [3:0] PH_CRC_2   = 4'd7;
   localparam logic [3:0] PH_CRC_1   = 4'd8;
   localparam logic [3:0] PH_CRC_0   = 4'd9;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [31:0] crc_ff, crc_in;
   logic [3:0]  phase_ff, phase_in;
   logic        mid_ff, mid_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic [3:0]  phase;
   logic [7:0]  cur_byte;
   logic [31:0] crc_base, crc_fin;
   logic        advance, fire, done;

   assign advance = !valid_ff || rsp_ready;
   assign fire    = head_valid && advance;
   assign phase   = mid_ff ? phase_ff : (head_cmd.is_start ? PH_SYNC_A : PH_LEN_LO);
   assign crc_fin = crc_ff ^ CRC_ONES;
   assign crc_base = (head_cmd.is_start && phase == PH_SYNC_A) ? CRC_ONES : crc_ff;
   assign done    = (phase == PH_CRC_0) || (phase == PH_LEN_LO && !head_cmd.close);
   assign pop     = fire && done;

   always_comb begin
      unique case (phase)
         PH_SYNC_A:  cur_byte = SYNC_A;
         PH_SYNC_B:  cur_byte = SYNC_B;
         PH_VERSION: cur_byte = VERSION_BYTE;
         PH_TYPE:    cur_byte = head_cmd.value;
         PH_LEN_HI:  cur_byte = head_cmd.length[15:8];
         PH_LEN_LO:  cur_byte = head_cmd.is_start ? head_cmd.length[7:0] : head_cmd.value;
         PH_CRC_3:   cur_byte = crc_fin[31:24];
         PH_CRC_2:   cur_byte = crc_fin[23:16];
         PH_CRC_1:   cur_byte = crc_fin[15:8];
         PH_CRC_0:   cur_byte = crc_fin[7:0];
         default:    cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      crc_in   = crc_ff;
      phase_in = phase_ff;
      mid_in   = mid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (fire) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = (phase == PH_CRC_0);
         phase_in = phase + 4'd1;
         mid_in   = !done;
         // CRC bytes themselves are not folded in
         if (phase <= PH_LEN_LO) begin
            crc_in = crc_byte(crc_base, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_ONES;
         phase_ff <= PH_SYNC_A;
         mid_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         phase_ff <= phase_in;
         mid_ff   <= mid_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

// ===== hw/rtl/frame_builder_crc32.sv =====
// Channel  Direction  Handshake            Payload
// req_     in         req_valid/req_ready  kind, frame_type, payload_length, data_byte
// rsp_     out        rsp_valid/rsp_ready  out_byte, last_of_frame
//
// Input beats are taken one per cycle while the command queue has room.
// The back end emits one output byte per cycle while not stalled: a payload beat
// gives 1 byte, a start 6 header bytes, and the CRC trailer 4 bytes at frame end.
// Synchronous active-high reset empties the queue and closes any open frame.
// Output stalls back up into the queue; the front keeps accepting until it fills.
module frame_builder_crc32
   import fbc_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_frame_type,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_frame
);

   logic    push, pop, not_full, head_valid;
   cmd_type push_cmd, head_cmd;

   assign req_ready = not_full;

   fbc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_frame_type     (req_frame_type),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   fbc_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .not_full   (not_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   fbc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
